### sv/gdw_pkg.sv
package gdw_pkg;

    // Exp table geometry
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int J_W               = $clog2(EXP_TABLE_ENTRIES);
    localparam int TBL_IDX_W         = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int P_W               = 16 + J_W;

    // Datapath widths
    localparam int INV_W   = 24;
    localparam int SQ_W    = 32;
    localparam int D2_W    = SQ_W + 1;
    localparam int EPROD_W = D2_W + INV_W;
    localparam int E_W     = 26;
    localparam int G_W     = 31;

    // Fixed-point constants
    localparam logic [63:0] LN2_Q30      = 64'd744261118;
    localparam logic [63:0] ONE_Q30_W    = 64'd1073741824;
    localparam logic [16:0] LOG2E_Q16    = 17'd94548;
    localparam logic [G_W-1:0] ONE_Q30   = 31'd1073741824;
    localparam int          SERIES_TERMS = 12;
    localparam int          K_MAX        = 30;

    // Accepting edge to the edge that takes the result
    localparam int PIPE_LATENCY = 13;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_INV_TWO_SIGMA_SQ = 2'd0,
        CFG_MAX_WEIGHT       = 2'd1,
        CFG_MIN_WEIGHT       = 2'd2
    } cfg_index_t;

    // Beat from the distance/scale pipe to the exp pipe
    typedef struct packed {
        logic               valid;
        logic [EPROD_W-1:0] prod;
    } gdw_scale_t;

    // Beat from the exp pipe to the blend stage
    typedef struct packed {
        logic           valid;
        logic [G_W-1:0] gain;
    } gdw_gain_t;

    // 2^-(i/N) in Q.30, i = 0..N
    typedef logic [EXP_TABLE_ENTRIES:0][G_W-1:0] exp_rom_t;

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] y;
        logic [63:0] term;
        longint      sum;
        for (int i = 0; i <= EXP_TABLE_ENTRIES; i++)
        begin
            y    = (64'(i) * LN2_Q30 + 64'(EXP_TABLE_ENTRIES / 2)) / 64'(EXP_TABLE_ENTRIES);
            term = ONE_Q30_W;
            sum  = longint'(ONE_Q30_W);
            for (int m = 1; m <= SERIES_TERMS; m++)
            begin
                term = ((term * y + 64'd536870912) >> 30) / 64'(m);
                if ((m % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            rom[i] = G_W'(sum);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

### sv/gaussian_distance_weight_unit.sv
// Gaussian distance weight: weight = (max - min) * exp(-d^2/(2 sigma^2)) + min.
// Pipeline: 13 stages in all (distance, scale, exp table, blend), from start to done.
// Throughput: one item per cycle; busy is low from the first edge after reset.
// Reset (rst_n low, async): pipe emptied, registers back to 1.0 / 1.0 / 0.
// The receiver cannot stall: each result is on the ports for one cycle only.
module gaussian_distance_weight_unit
    import gdw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] source_x,
    input  logic signed [15:0] source_y,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    output logic               done,
    output logic signed [31:0] weight,
    output logic               saturated
);

    logic               busy_reg;
    logic [INV_W-1:0]   inv_reg, inv_next;
    logic signed [31:0] max_reg, max_next;
    logic signed [31:0] min_reg, min_next;
    logic               in_valid;
    gdw_scale_t         scale;
    gdw_gain_t          gain;

    assign in_valid = start & ~busy_reg;
    assign busy     = busy_reg;

    // Config register writes; unknown indexes are dropped
    always_comb
    begin
        inv_next = inv_reg;
        max_next = max_reg;
        min_next = min_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_INV_TWO_SIGMA_SQ: inv_next = wr_data[INV_W-1:0];
                CFG_MAX_WEIGHT:       max_next = wr_data;
                CFG_MIN_WEIGHT:       min_next = wr_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            inv_reg  <= 24'd65536;
            max_reg  <= 32'sd65536;
            min_reg  <= 32'sd0;
        end
        else
        begin
            busy_reg <= 1'b0;
            inv_reg  <= inv_next;
            max_reg  <= max_next;
            min_reg  <= min_next;
        end
    end

    gdw_dist u_dist
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .source_x         (source_x),
        .source_y         (source_y),
        .target_x         (target_x),
        .target_y         (target_y),
        .inv_two_sigma_sq (inv_reg),
        .scale            (scale)
    );

    gdw_exp u_exp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .scale (scale),
        .gain  (gain)
    );

    gdw_blend u_blend
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .gain       (gain),
        .max_weight (max_reg),
        .min_weight (min_reg),
        .done       (done),
        .weight     (weight),
        .saturated  (saturated)
    );

    // One result per accepted beat, a fixed latency later, once the whole
    // window lies past reset
    a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, PIPE_LATENCY) |->
            (done == $past(start && !busy_reg, PIPE_LATENCY)))
        else $error("result strobe does not match accepted beats");

endmodule

### sv/gdw_dist.sv
module gdw_dist
    import gdw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [15:0]  source_x,
    input  logic signed [15:0]  source_y,
    input  logic signed [15:0]  target_x,
    input  logic signed [15:0]  target_y,
    input  logic [INV_W-1:0]    inv_two_sigma_sq,
    output gdw_scale_t          scale
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [16:0]        adx_reg, ady_reg, adx_next, ady_next;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic [D2_W-1:0]    d2_reg, d2_next;
    logic [EPROD_W-1:0] prod_reg, prod_next;
    logic [16:0]        dx, dy;
    logic [33:0]        sqx_full, sqy_full;

    // Stage 1: coordinate differences, magnitude only
    always_comb
    begin
        dx       = {source_x[15], source_x} - {target_x[15], target_x};
        dy       = {source_y[15], source_y} - {target_y[15], target_y};
        adx_next = dx[16] ? (17'd0 - dx) : dx;
        ady_next = dy[16] ? (17'd0 - dy) : dy;
    end

    // Stage 2: squares (|d| <= 65535, so each fits 32 bits)
    always_comb
    begin
        sqx_full = adx_reg * adx_reg;
        sqy_full = ady_reg * ady_reg;
        sqx_next = sqx_full[SQ_W-1:0];
        sqy_next = sqy_full[SQ_W-1:0];
    end

    // Stage 3: squared distance, Q17.16
    assign d2_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Stage 4: scale by 1/(2 sigma^2)
    assign prod_next = d2_reg * inv_two_sigma_sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        d2_reg   <= d2_next;
        prod_reg <= prod_next;
    end

    assign scale.valid = v4_reg;
    assign scale.prod  = prod_reg;

endmodule

### sv/gdw_exp.sv
module gdw_exp
    import gdw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  gdw_scale_t scale,
    output gdw_gain_t  gain
);

    localparam int EXP_STAGES = 7;

    logic v5_reg, v6_reg, v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;

    // Stage 5
    logic [EPROD_W-1:0] e_sum;
    logic [E_W-1:0]     e_reg, e_next;
    logic               big5_reg, big5_next;
    // Stage 6
    logic [42:0]        tprod_reg, tprod_next;
    logic               big6_reg;
    // Stage 7
    logic [42:0]        t_sum;
    logic [10:0]        k_hi;
    logic [4:0]         k7_reg, k7_next;
    logic [15:0]        f7_reg, f7_next;
    logic               off7_reg, off7_next;
    // Stage 8
    logic [P_W-1:0]       p;
    logic [TBL_IDX_W-1:0] idx0, idx1;
    logic [G_W-1:0]       tj_reg, tj_next, t1;
    logic signed [31:0]   delta_reg, delta_next;
    logic [15:0]          r_reg, r_next;
    logic [4:0]           k8_reg;
    logic                 off8_reg;
    // Stage 9
    logic signed [48:0]   dr_reg, dr_next;
    logic [G_W-1:0]       tj9_reg;
    logic [4:0]           k9_reg;
    logic                 off9_reg;
    // Stage 10
    logic signed [48:0]   dr_rnd;
    logic signed [32:0]   dr_sh, v_sum;
    logic [G_W-1:0]       v_reg, v_next;
    logic [4:0]           k10_reg;
    logic                 off10_reg;
    // Stage 11
    logic [31:0]          rnd, g_sum;
    logic [G_W-1:0]       g_reg, g_next;

    // Stage 5: round the exponent to Q.16, flag arguments past the table
    always_comb
    begin
        e_sum     = scale.prod + EPROD_W'(32768);
        e_next    = e_sum[16 +: E_W];
        big5_next = |e_sum[EPROD_W-1:16+E_W];
    end

    // Stage 6: e * log2(e)
    assign tprod_next = e_reg * LOG2E_Q16;

    // Stage 7: split into integer shift k and fraction f
    always_comb
    begin
        t_sum     = tprod_reg + 43'd32768;
        k_hi      = t_sum[42:32];
        f7_next   = t_sum[31:16];
        k7_next   = k_hi[4:0];
        off7_next = big6_reg | (k_hi > 11'(K_MAX));
    end

    // Stage 8: table lookup of the two neighbors
    always_comb
    begin
        p          = P_W'(f7_reg) * P_W'(EXP_TABLE_ENTRIES);
        idx0       = TBL_IDX_W'(p[P_W-1:16]);
        idx1       = idx0 + TBL_IDX_W'(1);
        tj_next    = EXP_ROM[idx0];
        t1         = EXP_ROM[idx1];
        r_next     = p[15:0];
        delta_next = $signed({1'b0, t1}) - $signed({1'b0, tj_next});
    end

    // Stage 9: slope times fraction
    assign dr_next = delta_reg * $signed({1'b0, r_reg});

    // Stage 10: interpolated 2^-f, rounded
    always_comb
    begin
        dr_rnd = dr_reg + 49'sd32768;
        dr_sh  = dr_rnd[48:16];
        v_sum  = $signed({2'b00, tj9_reg}) + dr_sh;
        v_next = v_sum[G_W-1:0];
    end

    // Stage 11: rounded shift by k, zero past the table
    always_comb
    begin
        rnd   = (k10_reg == 5'd0) ? 32'd0 : (32'd1 << (k10_reg - 5'd1));
        g_sum = ({1'b0, v_reg} + rnd) >> k10_reg;
        g_next = off10_reg ? '0 : g_sum[G_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else
        begin
            v5_reg  <= scale.valid;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg     <= e_next;
        big5_reg  <= big5_next;
        tprod_reg <= tprod_next;
        big6_reg  <= big5_reg;
        k7_reg    <= k7_next;
        f7_reg    <= f7_next;
        off7_reg  <= off7_next;
        tj_reg    <= tj_next;
        delta_reg <= delta_next;
        r_reg     <= r_next;
        k8_reg    <= k7_reg;
        off8_reg  <= off7_reg;
        dr_reg    <= dr_next;
        tj9_reg   <= tj_reg;
        k9_reg    <= k8_reg;
        off9_reg  <= off8_reg;
        v_reg     <= v_next;
        k10_reg   <= k9_reg;
        off10_reg <= off9_reg;
        g_reg     <= g_next;
    end

    assign gain.valid = v11_reg;
    assign gain.gain  = g_reg;

    // Interpolating a falling table never overshoots 1.0
    a_gain_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        gain.valid |-> (gain.gain <= ONE_Q30))
        else $error("exp gain above 1.0");

    // Every beat in comes out after a fixed number of stages, once the
    // whole window lies past reset
    a_exp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, EXP_STAGES) |-> (gain.valid == $past(scale.valid, EXP_STAGES)))
        else $error("exp pipe lost or invented a beat");

endmodule

### sv/gdw_blend.sv
module gdw_blend
    import gdw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  gdw_gain_t          gain,
    input  logic signed [31:0] max_weight,
    input  logic signed [31:0] min_weight,
    output logic               done,
    output logic signed [31:0] weight,
    output logic               saturated
);

    localparam logic signed [34:0] WIDE_MAX = 35'sd2147483647;
    localparam logic signed [34:0] WIDE_MIN = -35'sd2147483648;

    logic signed [32:0] diff;
    logic [32:0]        dmag;
    logic [31:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic               v12_reg, done_reg;
    logic [62:0]        mprod_reg, mprod_next;
    logic [62:0]        mprod_rnd;
    logic [32:0]        pr;
    logic signed [34:0] w;
    logic signed [31:0] weight_reg, weight_next;
    logic               sat_reg, sat_next;

    // Span between the two weights, refreshed every cycle from config
    always_comb
    begin
        diff     = 33'(max_weight) - 33'(min_weight);
        neg_next = diff[32];
        dmag     = diff[32] ? (33'd0 - diff) : diff;
        mag_next = dmag[31:0];
    end

    // Stage 12: span times gain
    assign mprod_next = mag_reg * gain.gain;

    // Stage 13: round, offset by min, clip to 32 bits
    always_comb
    begin
        mprod_rnd = mprod_reg + 63'd536870912;
        pr        = mprod_rnd[62:30];
        if (neg_reg)
            w = 35'(min_weight) - $signed({2'b00, pr});
        else
            w = 35'(min_weight) + $signed({2'b00, pr});
        if (w > WIDE_MAX)
        begin
            weight_next = 32'sh7FFFFFFF;
            sat_next    = 1'b1;
        end
        else if (w < WIDE_MIN)
        begin
            weight_next = 32'sh80000000;
            sat_next    = 1'b1;
        end
        else
        begin
            weight_next = w[31:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v12_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v12_reg  <= gain.valid;
            done_reg <= v12_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        mprod_reg  <= mprod_next;
        weight_reg <= weight_next;
        sat_reg    <= sat_next;
    end

    assign done      = done_reg;
    assign weight    = weight_reg;
    assign saturated = sat_reg;

    // Gain stays in [0,1], so the blend never clips
    a_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !saturated)
        else $error("weight clipped");

    // Result lies between the two configured weights
    a_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((weight >= min_weight && weight <= max_weight) ||
                  (weight <= min_weight && weight >= max_weight)))
        else $error("weight outside min/max span");

endmodule

### test/gdw_weight_checker.sv
`timescale 1ns / 1ps

module gdw_weight_checker
    import gdw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] source_x,
    input  logic signed [15:0] source_y,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    input  logic               done,
    input  logic signed [31:0] weight,
    input  logic               saturated,
    output int                 fail_count,
    output int                 outstanding
);

    localparam int        TBL_N       = EXP_TABLE_ENTRIES;
    localparam bit [63:0] LN2_FRAC    = 64'd744261118;
    localparam bit [63:0] LOG2E_FRAC  = 64'd94548;
    localparam bit [63:0] UNITY       = 64'd1 << 30;
    localparam int        TAYLOR_TERMS = 12;
    localparam int        SHIFT_LIMIT = 30;
    localparam longint    W_TOP       = 64'sd2147483647;
    localparam longint    W_BOT       = -64'sd2147483648;
    localparam int        MAX_REPORTS = 20;

    typedef struct {
        logic signed [31:0] w_val;
        logic               sat;
    } weight_beat_t;

    // 2^-(i/N) in Q.30, interpolation points
    bit [63:0]           pow2_frac [0:TBL_N];

    // Shadow of the config registers
    logic [23:0]         inv_scale;
    logic signed [31:0]  near_weight;
    logic signed [31:0]  far_weight;

    weight_beat_t        weight_due_q [$];

    // Alternating integer series for exp(-i*ln2/N)
    function automatic bit [63:0] pow2_frac_entry(input int idx);
        bit [63:0] y;
        bit [63:0] term;
        longint    acc;
        y    = (64'(idx) * LN2_FRAC + 64'(TBL_N / 2)) / 64'(TBL_N);
        term = UNITY;
        acc  = longint'(UNITY);
        for (int m = 1; m <= TAYLOR_TERMS; m++)
        begin
            term = ((term * y + (64'd1 << 29)) >> 30) / 64'(m);
            if ((m % 2) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    function automatic weight_beat_t predict_weight(input logic signed [15:0] sx,
                                                    input logic signed [15:0] sy,
                                                    input logic signed [15:0] tx,
                                                    input logic signed [15:0] ty);
        weight_beat_t res;
        int           dx;
        int           dy;
        bit [63:0]    ax, ay, d2, e, t, k, f, p, j, r, v, g, mag, prod;
        longint       hi, lo, diff, w;
        dx = int'(sx) - int'(tx);
        dy = int'(sy) - int'(ty);
        ax = 64'((dx < 0) ? -dx : dx);
        ay = 64'((dy < 0) ? -dy : dy);
        d2 = ax * ax + ay * ay;
        e  = (d2 * 64'(inv_scale) + (64'd1 << 15)) >> 16;
        g  = 64'd0;

        // exp(-e) = 2^-(k+f); past the table range the gain is zero
        if (e < (64'd1 << 26))
        begin
            t = (e * LOG2E_FRAC + (64'd1 << 15)) >> 16;
            k = t >> 16;
            if (k <= 64'(SHIFT_LIMIT))
            begin
                f = t & 64'hFFFF;
                p = f * 64'(TBL_N);
                j = p >> 16;
                r = p & 64'hFFFF;
                if (j >= 64'(TBL_N))
                    j = 64'(TBL_N - 1);
                v = (pow2_frac[j] * (64'd65536 - r) + pow2_frac[j + 1] * r
                     + (64'd1 << 15)) >> 16;
                if (k > 0)
                    g = (v + (64'd1 << (k - 1))) >> k;
                else
                    g = v;
            end
        end

        // Blend between the far and near weights, then clip
        hi   = longint'(near_weight);
        lo   = longint'(far_weight);
        diff = hi - lo;
        mag  = 64'((diff < 0) ? -diff : diff);
        prod = (mag * g + (64'd1 << 29)) >> 30;
        w    = (diff < 0) ? lo - longint'(prod) : lo + longint'(prod);
        res.sat = 1'b0;
        if (w > W_TOP)
        begin
            w       = W_TOP;
            res.sat = 1'b1;
        end
        else if (w < W_BOT)
        begin
            w       = W_BOT;
            res.sat = 1'b1;
        end
        res.w_val = 32'(w);
        return res;
    endfunction

    initial
    begin
        for (int i = 0; i <= TBL_N; i++)
            pow2_frac[i] = pow2_frac_entry(i);
    end

    always @(posedge clk or negedge rst_n)
    begin
        weight_beat_t due;
        if (!rst_n)
        begin
            inv_scale   = 24'd65536;
            near_weight = 32'sd65536;
            far_weight  = 32'sd0;
            weight_due_q.delete();
            outstanding = 0;
        end
        else
        begin
            // Result beat against the oldest pending prediction
            if (done)
            begin
                if (weight_due_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: weight expected none, actual %0d", $time, weight);
                end
                else
                begin
                    due = weight_due_q.pop_front();
                    if (weight !== due.w_val)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: weight expected %0d, actual %0d",
                                     $time, due.w_val, weight);
                    end
                    if (saturated !== due.sat)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: saturated expected %0b, actual %0b",
                                     $time, due.sat, saturated);
                    end
                end
            end

            // Accepted item beat
            if (start && !busy)
                weight_due_q.push_back(predict_weight(source_x, source_y,
                                                      target_x, target_y));

            // Register writes; other indexes are dropped
            if (wr_en)
            begin
                if (wr_index == CFG_INV_TWO_SIGMA_SQ)
                    inv_scale = wr_data[23:0];
                else if (wr_index == CFG_MAX_WEIGHT)
                    near_weight = wr_data;
                else if (wr_index == CFG_MIN_WEIGHT)
                    far_weight = wr_data;
            end
            outstanding = weight_due_q.size();
        end
    end

endmodule

### test/tb_gaussian_distance_weight_unit.sv
`timescale 1ns / 1ps

module tb_gaussian_distance_weight_unit;
    import gdw_pkg::*;

    localparam int         DRAIN_CYCLES    = 20;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         RANDOM_PHASES   = 8;
    localparam int         ITEMS_PER_PHASE = 200;
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic signed [15:0] source_x = '0;
    logic signed [15:0] source_y = '0;
    logic signed [15:0] target_x = '0;
    logic signed [15:0] target_y = '0;
    logic               wr_en    = 1'b0;
    logic [1:0]         wr_index = CFG_INV_TWO_SIGMA_SQ;
    logic [31:0]        wr_data  = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] weight;
    logic               saturated;

    int fail_count;
    int outstanding;
    int idle_cycles = 0;
    bit no_gaps     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gaussian_distance_weight_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .source_x  (source_x),
        .source_y  (source_y),
        .target_x  (target_x),
        .target_y  (target_y),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .done      (done),
        .weight    (weight),
        .saturated (saturated)
    );

    gdw_weight_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .source_x    (source_x),
        .source_y    (source_y),
        .target_x    (target_x),
        .target_y    (target_y),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .done        (done),
        .weight      (weight),
        .saturated   (saturated),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Watchdog: cycles with neither an item nor a result beat
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // One item beat, with an optional random gap in front of it
    task automatic send_point(input logic signed [15:0] sx, input logic signed [15:0] sy,
                              input logic signed [15:0] tx, input logic signed [15:0] ty);
        int roll;
        int gap;
        gap = 0;
        if (!no_gaps)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 90)
                gap = $urandom_range(8, 40);
            else if (roll >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        source_x <= sx;
        source_y <= sy;
        target_x <= tx;
        target_y <= ty;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
    endtask

    // Drain the pipe, then load a new register setting
    task automatic configure(input logic [31:0] inv_word, input logic [31:0] near_w,
                             input logic [31:0] far_w, input bit poke_spare);
        start <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (poke_spare)
            write_reg(CFG_SPARE_INDEX, $urandom);
        write_reg(CFG_INV_TWO_SIGMA_SQ, inv_word);
        write_reg(CFG_MAX_WEIGHT, near_w);
        write_reg(CFG_MIN_WEIGHT, far_w);
        wr_en <= 1'b0;
    endtask

    // Coordinate delta with a random number of significant bits
    function automatic logic [15:0] near_offset();
        int          bits;
        logic [31:0] mag;
        bits = $urandom_range(0, 16);
        mag  = $urandom & ((32'd1 << bits) - 32'd1);
        return ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 262144)) - 32'd131072;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return 32'd0;
        endcase
    endfunction

    initial
    begin
        int          width;
        logic [31:0] inv_word;
        logic [15:0] sx;
        logic [15:0] sy;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: sigma term 1.0, weights 1.0 and 0
        send_point(0, 0, 0, 0);
        send_point(1, 0, 0, 0);
        send_point(0, -1, 0, 0);
        send_point(128, 0, 0, 0);
        send_point(256, 256, 0, 0);
        send_point(0, 0, -256, 512);
        // shift amount just under, at and past its limit
        send_point(1163, 0, 0, 0);
        send_point(1177, 0, 0, 0);
        send_point(1200, 0, 0, 0);
        send_point(0, 1536, 0, 0);
        // coordinate extremes, the first two with the exponent past the table
        send_point(-32768, -32768, 32767, 32767);
        send_point(32767, 32767, -32768, -32768);
        send_point(-32768, 32767, -32768, 32767);

        // Zero reciprocal (upper data bits set), widest positive span
        configure(32'hFF00_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(0, 0, 0, 0);
        send_point(-32768, -32768, 32767, 32767);
        send_point(100, -200, -300, 400);

        // Largest reciprocal, widest negative span, unused index poked
        configure(32'h00FF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_point(0, 0, 0, 0);
        send_point(1, 0, 0, 0);
        send_point(0, 0, 0, 1);
        send_point(32767, -32768, -32768, 32767);

        // Random settings; mostly nearby point pairs so the gain is nonzero
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            width    = $urandom_range(0, 24);
            inv_word = {8'($urandom), 24'($urandom) & ((24'd1 << width) - 24'd1)};
            configure(inv_word, pick_weight(), pick_weight(), 1'b0);
            no_gaps = ((ph % 4) == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                sx = 16'($urandom);
                sy = 16'($urandom);
                if ($urandom_range(0, 9) == 0)
                    send_point(sx, sy, 16'($urandom), 16'($urandom));
                else
                    send_point(sx, sy, sx - near_offset(), sy - near_offset());
            end
        end

        start <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
